/* rtl/core/omr_pkg.sv */
package omr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned DWORD_W  = 2 * WORD_W;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned MAX_LEN  = 32;
  localparam int unsigned MIN_LEN  = 2;
  localparam int unsigned NUM_VAR  = 4;
  localparam int unsigned NUM_CAND = NUM_VAR * WORD_W;
  localparam int unsigned GRP_SIZE = 4;
  localparam int unsigned NUM_GRP  = NUM_CAND / GRP_SIZE;
  localparam int unsigned NUM_MID  = NUM_GRP / GRP_SIZE;

  // Register index as decoded from paddr[2].
  localparam logic CFG_IDX_CHAIN_LEN = 1'b0;

  typedef logic [DWORD_W-1:0] dword_t;

  // One orbit candidate, held left-justified so that the ring length drops out of compares.
  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  word;
    logic [SHIFT_W-1:0] shift;
    logic               refl;
    logic               inv;
  } cand_t;

  // The earlier candidate is passed as a; the later one wins only when strictly smaller.
  function automatic cand_t cand_min(cand_t a, cand_t b);
    cand_t r;
    r = a;
    if (b.ok && (!a.ok || (b.word < a.word))) begin
      r = b;
    end
    return r;
  endfunction

endpackage

/* rtl/core/omr_window_min.sv */
module omr_window_min (
  input  omr_pkg::dword_t             dw_i [omr_pkg::NUM_VAR],
  input  logic [omr_pkg::LEN_W-1:0]   len_i,
  input  logic [omr_pkg::WORD_W-1:0]  top_mask_i,
  output omr_pkg::cand_t              grp_o [omr_pkg::NUM_GRP]
);

  omr_pkg::cand_t cand [omr_pkg::NUM_CAND];

  // Each rotation is a fixed window of the doubled word, so no shifter is needed here.
  always_comb begin
    for (int v = 0; v < omr_pkg::NUM_VAR; v++) begin
      for (int k = 0; k < omr_pkg::WORD_W; k++) begin
        cand[v*omr_pkg::WORD_W + k].word  =
          dw_i[v][omr_pkg::DWORD_W-1-k -: omr_pkg::WORD_W] & top_mask_i;
        cand[v*omr_pkg::WORD_W + k].ok    = (omr_pkg::LEN_W'(k) < len_i);
        cand[v*omr_pkg::WORD_W + k].shift = omr_pkg::SHIFT_W'(k);
        cand[v*omr_pkg::WORD_W + k].refl  = 1'((v & 1) != 0);
        cand[v*omr_pkg::WORD_W + k].inv   = 1'((v & 2) != 0);
      end
    end
  end

  always_comb begin
    for (int g = 0; g < omr_pkg::NUM_GRP; g++) begin
      grp_o[g] = omr_pkg::cand_min(
                   omr_pkg::cand_min(cand[4*g],     cand[4*g + 1]),
                   omr_pkg::cand_min(cand[4*g + 2], cand[4*g + 3]));
    end
  end

endmodule

/* rtl/core/orbit_minimum_representative.sv */
// Orbit minimum representative of a spin ring.
// Each input item is one spin configuration on spin_word_i; only the low chain_len bits
// take part. The result item carries the smallest word among all rotations of the word,
// its bit reversal, its complement and its reversed complement, together with the left
// rotation count and the reflection and inversion flags that reach it. Ties go to the
// earliest candidate in the order plain, reflected, inverted, reflected and inverted.
// Both channels use valid and stall; an item moves when valid is high and stall is low.
// The datapath is a six-stage pipeline: variant forming, ring doubling, window compare
// down to 32 survivors, down to 8, down to 1, and output alignment. A new item may be
// accepted every cycle while the receiver does not stall.
// A stall from the receiver holds the output register; bubbles inside the pipeline are
// still filled, so in_stall_o rises only once every stage holds an item.
// chain_len is written through the APB port at byte address 0 and should only be
// changed while the pipeline is empty. Reset empties the pipeline and sets chain_len
// to 32; there is no other state and no clearing pass.
module orbit_minimum_representative (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [omr_pkg::WORD_W-1:0]    spin_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [omr_pkg::WORD_W-1:0]    rep_word_o,
  output logic [omr_pkg::SHIFT_W-1:0]   shift_count_o,
  output logic                          reflected_o,
  output logic                          inverted_o
);

  localparam int unsigned STG_VAR  = 0;
  localparam int unsigned STG_DW   = 1;
  localparam int unsigned STG_GRP  = 2;
  localparam int unsigned STG_MID  = 3;
  localparam int unsigned STG_BEST = 4;
  localparam int unsigned STG_OUT  = 5;
  localparam int unsigned NUM_STG  = 6;

  // Configuration: the raw register is kept for read-back, the clamped length drives logic.
  logic                        cfg_wr;
  logic [omr_pkg::LEN_W-1:0]   chain_len_q, chain_len_d;
  logic [omr_pkg::LEN_W-1:0]   len_q, len_d;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == omr_pkg::CFG_IDX_CHAIN_LEN);
  assign chain_len_d = pwdata[omr_pkg::LEN_W-1:0];

  always_comb begin
    len_d = chain_len_d;
    if (chain_len_d < omr_pkg::LEN_W'(omr_pkg::MIN_LEN)) begin
      len_d = omr_pkg::LEN_W'(omr_pkg::MIN_LEN);
    end else if (chain_len_d > omr_pkg::LEN_W'(omr_pkg::MAX_LEN)) begin
      len_d = omr_pkg::LEN_W'(omr_pkg::MAX_LEN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_len_q <= omr_pkg::LEN_W'(omr_pkg::MAX_LEN);
      len_q       <= omr_pkg::LEN_W'(omr_pkg::MAX_LEN);
    end else if (cfg_wr) begin
      chain_len_q <= chain_len_d;
      len_q       <= len_d;
    end
  end

  assign prdata = (paddr[2] == omr_pkg::CFG_IDX_CHAIN_LEN) ? 32'(chain_len_q) : '0;

  // Masks that follow from the ring length. Shifting by 32 yields zero, which covers L = 32.
  logic [omr_pkg::WORD_W-1:0] len_mask;
  logic [omr_pkg::WORD_W-1:0] top_mask;
  logic [omr_pkg::LEN_W-1:0]  lj_sh;

  assign len_mask = ~({omr_pkg::WORD_W{1'b1}} << len_q);
  assign top_mask = ~({omr_pkg::WORD_W{1'b1}} >> len_q);
  assign lj_sh    = omr_pkg::LEN_W'(omr_pkg::WORD_W) - len_q;

  // Pipeline flow control. A stage may load when it is empty or when its content moves on.
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG:0]   rdy;
  logic [NUM_STG-1:0] ld;

  always_comb begin
    rdy[NUM_STG] = !out_stall_i;
    for (int k = NUM_STG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && in_valid_i;
    for (int k = 1; k < NUM_STG; k++) begin
      ld[k] = rdy[k] && vld_q[k-1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage one: the four variants, left-justified in the word. Reversing the masked word
  // across all 32 bits already gives the left-justified reversal of the L-bit ring, and the
  // left shift drops the stray bits above L.
  logic [omr_pkg::WORD_W-1:0] masked;
  logic [omr_pkg::WORD_W-1:0] lj_word;
  logic [omr_pkg::WORD_W-1:0] rv_word;
  logic [omr_pkg::WORD_W-1:0] var_d [omr_pkg::NUM_VAR];
  logic [omr_pkg::WORD_W-1:0] var_q [omr_pkg::NUM_VAR];

  always_comb begin
    masked  = spin_word_i & len_mask;
    lj_word = spin_word_i << lj_sh;
    for (int i = 0; i < omr_pkg::WORD_W; i++) begin
      rv_word[i] = masked[omr_pkg::WORD_W-1-i];
    end
    var_d[0] = lj_word;
    var_d[1] = rv_word;
    var_d[2] = ~lj_word & top_mask;
    var_d[3] = ~rv_word & top_mask;
  end

  always_ff @(posedge clk_i) begin
    if (ld[STG_VAR]) begin
      var_q <= var_d;
    end
  end

  // Stage two: two copies of each ring side by side at the top of a double word, so that
  // every rotation is a fixed 32-bit window.
  omr_pkg::dword_t dw_d [omr_pkg::NUM_VAR];
  omr_pkg::dword_t dw_q [omr_pkg::NUM_VAR];

  always_comb begin
    for (int v = 0; v < omr_pkg::NUM_VAR; v++) begin
      dw_d[v] = {var_q[v], {omr_pkg::WORD_W{1'b0}}}
              | ({var_q[v], {omr_pkg::WORD_W{1'b0}}} >> len_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[STG_DW]) begin
      dw_q <= dw_d;
    end
  end

  // Stage three: all 128 candidates, reduced four to one.
  omr_pkg::cand_t grp_d [omr_pkg::NUM_GRP];
  omr_pkg::cand_t grp_q [omr_pkg::NUM_GRP];

  omr_window_min u_window_min (
    .dw_i       (dw_q),
    .len_i      (len_q),
    .top_mask_i (top_mask),
    .grp_o      (grp_d)
  );

  always_ff @(posedge clk_i) begin
    if (ld[STG_GRP]) begin
      grp_q <= grp_d;
    end
  end

  // Stage four: 32 survivors down to 8, always keeping the earlier one on a tie.
  omr_pkg::cand_t mid_d [omr_pkg::NUM_MID];
  omr_pkg::cand_t mid_q [omr_pkg::NUM_MID];

  always_comb begin
    for (int g = 0; g < omr_pkg::NUM_MID; g++) begin
      mid_d[g] = omr_pkg::cand_min(
                   omr_pkg::cand_min(grp_q[4*g],     grp_q[4*g + 1]),
                   omr_pkg::cand_min(grp_q[4*g + 2], grp_q[4*g + 3]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[STG_MID]) begin
      mid_q <= mid_d;
    end
  end

  // Stage five: 8 down to the winner in three levels.
  omr_pkg::cand_t lvl1 [4];
  omr_pkg::cand_t lvl2 [2];
  omr_pkg::cand_t best_d;
  omr_pkg::cand_t best_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = omr_pkg::cand_min(mid_q[2*i], mid_q[2*i + 1]);
    end
    for (int i = 0; i < 2; i++) begin
      lvl2[i] = omr_pkg::cand_min(lvl1[2*i], lvl1[2*i + 1]);
    end
    best_d = omr_pkg::cand_min(lvl2[0], lvl2[1]);
  end

  always_ff @(posedge clk_i) begin
    if (ld[STG_BEST]) begin
      best_q <= best_d;
    end
  end

  // Stage six: the output register, with the winner moved back to the low L bits.
  logic [omr_pkg::WORD_W-1:0]  rep_word_q;
  logic [omr_pkg::SHIFT_W-1:0] shift_count_q;
  logic                        reflected_q;
  logic                        inverted_q;

  always_ff @(posedge clk_i) begin
    if (ld[STG_OUT]) begin
      rep_word_q    <= best_q.word >> lj_sh;
      shift_count_q <= best_q.shift;
      reflected_q   <= best_q.refl;
      inverted_q    <= best_q.inv;
    end
  end

  assign out_valid_o   = vld_q[STG_OUT];
  assign rep_word_o    = rep_word_q;
  assign shift_count_o = shift_count_q;
  assign reflected_o   = reflected_q;
  assign inverted_o    = inverted_q;

`ifndef NO_ASSERTIONS
  // The representative never has bits above the ring length.
  a_rep_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((rep_word_o & ~len_mask) == '0))
    else $error("representative has bits above the ring length");

  // The rotation count of the winner lies inside the ring.
  a_shift_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (omr_pkg::LEN_W'(shift_count_o) < len_q))
    else $error("rotation count outside the ring");

  // Input is only held off when every stage holds an item.
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");
`endif

endmodule
